// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define RBT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define RBT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define RBT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rbt_pkg.sv =====
// ----------------------------------------------------------------------------
// rbt_pkg
// Types and constants of the rated timer binding table.
// ----------------------------------------------------------------------------
package rbt_pkg;

  localparam int ACTION_W    = 3;
  localparam int CHIP_W      = 4;
  localparam int RATING_W    = 10;
  localparam int MASK_W      = 8;
  localparam int MASK_IDX_W  = $clog2(MASK_W);
  localparam int CPU_W       = 8;
  localparam int POS_W       = 5;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 5;
  localparam int NUM_HANDLES = 2 ** CHIP_W;

  localparam int MAX_DEVICES_DEF = 16;
  localparam int CPU_COUNT_DEF   = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_REGISTER   = 3'd0,
    ACT_UNREGISTER = 3'd1,
    ACT_BIND       = 3'd2,
    ACT_UNBIND     = 3'd3,
    ACT_GET        = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FAIL    = 2'd1,
    STATUS_NOT_REG = 2'd2
  } status_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [CHIP_W-1:0]   chip_id;
    logic [RATING_W-1:0] rating;
    logic [MASK_W-1:0]   cpu_mask;
    logic [CPU_W-1:0]    cpu;
    logic [POS_W-1:0]    list_position;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CHIP_W-1:0]   chosen_chip;
    logic [COUNT_W-1:0]  device_count;
  } result_t;

  typedef struct packed {
    logic [RATING_W-1:0] rating;
    logic [MASK_W-1:0]   cpus;
  } dev_attr_t;

  typedef struct packed {
    logic              we;
    logic [CHIP_W-1:0] waddr;
    dev_attr_t         wdata;
    logic [CHIP_W-1:0] raddr;
  } dev_req_t;

endpackage

// ===== rtl/core/rbt_dev_mem.sv =====
// ----------------------------------------------------------------------------
// rbt_dev_mem
// Per-handle device attribute RAM (rating, CPU mask), registered read.
// ----------------------------------------------------------------------------
module rbt_dev_mem (
  input  logic               clk_i,
  input  rbt_pkg::dev_req_t  req_i,
  output rbt_pkg::dev_attr_t rdata_o
);
  import rbt_pkg::*;

  dev_attr_t mem [NUM_HANDLES];
  dev_attr_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rbt_order_mem.sv =====
// ----------------------------------------------------------------------------
// rbt_order_mem
// Registration order list RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rbt_order_mem #(
  parameter int  MAX_DEVICES = rbt_pkg::MAX_DEVICES_DEF,
  localparam int IdxW        = $clog2(MAX_DEVICES)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [IdxW-1:0]           waddr_i,
  input  logic [rbt_pkg::CHIP_W-1:0] wdata_i,
  input  logic [IdxW-1:0]           raddr_i,
  output logic [rbt_pkg::CHIP_W-1:0] rdata_o
);
  import rbt_pkg::*;

  logic [CHIP_W-1:0] mem [MAX_DEVICES];
  logic [CHIP_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbt_ctrl
// Sequencer: flags, list length, order scan, unregister compaction, bind search.
// ----------------------------------------------------------------------------
module rbt_ctrl #(
  parameter int  MAX_DEVICES = rbt_pkg::MAX_DEVICES_DEF,
  parameter int  CPU_COUNT   = rbt_pkg::CPU_COUNT_DEF,
  localparam int IdxW        = $clog2(MAX_DEVICES)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  rbt_pkg::item_t             item_i,
  output logic                       result_valid_o,
  output rbt_pkg::result_t           result_o,
  output logic                       ord_we_o,
  output logic [IdxW-1:0]            ord_waddr_o,
  output logic [rbt_pkg::CHIP_W-1:0] ord_wdata_o,
  output logic [IdxW-1:0]            ord_raddr_o,
  input  logic [rbt_pkg::CHIP_W-1:0] ord_rdata_i,
  output rbt_pkg::dev_req_t          dev_req_o,
  input  rbt_pkg::dev_attr_t         dev_rdata_i
);
  import rbt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_UNREG = 4'b0010,
    ST_BIND  = 4'b0100,
    ST_GET   = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  item_t                   item_q, item_d;
  logic [COUNT_W-1:0]      len_q, len_d;
  logic [NUM_HANDLES-1:0]  present_q, present_d;
  logic [NUM_HANDLES-1:0]  bound_q, bound_d;
  logic [COUNT_W-1:0]      rd_cnt_q, rd_cnt_d;
  logic                    p1_vld_q, p1_vld_d;
  logic [COUNT_W-1:0]      p1_pos_q, p1_pos_d;
  logic                    p2_vld_q, p2_vld_d;
  logic [CHIP_W-1:0]       p2_chip_q, p2_chip_d;
  logic                    p2_last_q, p2_last_d;
  logic                    found_q, found_d;
  logic                    got_q, got_d;
  logic [RATING_W-1:0]     best_q, best_d;
  logic [CHIP_W-1:0]       chosen_q, chosen_d;
  logic                    result_valid_q;
  result_t                 result_q;

  logic                    accept;
  logic                    fin;
  status_e                 fin_status;
  logic [CHIP_W-1:0]       fin_chip;
  logic [COUNT_W-1:0]      last_pos;

  assign accept   = start && (state_q == ST_IDLE);
  assign busy     = (state_q != ST_IDLE);
  assign last_pos = len_q - COUNT_W'(1);

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    len_d      = len_q;
    present_d  = present_q;
    bound_d    = bound_q;
    rd_cnt_d   = rd_cnt_q;
    p1_vld_d   = 1'b0;
    p1_pos_d   = p1_pos_q;
    p2_vld_d   = 1'b0;
    p2_chip_d  = p2_chip_q;
    p2_last_d  = 1'b0;
    found_d    = found_q;
    got_d      = got_q;
    best_d     = best_q;
    chosen_d   = chosen_q;
    fin        = 1'b0;
    fin_status = STATUS_FAIL;
    fin_chip   = '0;

    ord_we_o    = 1'b0;
    ord_waddr_o = IdxW'(len_q);
    ord_wdata_o = item_i.chip_id;
    ord_raddr_o = IdxW'(rd_cnt_q);

    dev_req_o.we           = 1'b0;
    dev_req_o.waddr        = item_i.chip_id;
    dev_req_o.wdata.rating = item_i.rating;
    dev_req_o.wdata.cpus   = item_i.cpu_mask;
    dev_req_o.raddr        = ord_rdata_i;

    if (state_q inside {ST_UNREG, ST_BIND}) begin
      if (rd_cnt_q < len_q) begin
        p1_vld_d = 1'b1;
        p1_pos_d = rd_cnt_q;
        rd_cnt_d = rd_cnt_q + COUNT_W'(1);
      end
    end

    case (state_q)
      ST_IDLE: begin
        ord_raddr_o = IdxW'(item_i.list_position);
        if (accept) begin
          item_d   = item_i;
          rd_cnt_d = '0;
          found_d  = 1'b0;
          got_d    = 1'b0;
          best_d   = '0;
          chosen_d = '0;
          case (action_e'(item_i.action))
            ACT_REGISTER: begin
              fin = 1'b1;
              if (!present_q[item_i.chip_id] && (32'(len_q) < MAX_DEVICES)) begin
                ord_we_o                   = 1'b1;
                dev_req_o.we               = 1'b1;
                present_d[item_i.chip_id] = 1'b1;
                bound_d[item_i.chip_id]   = 1'b0;
                len_d                      = len_q + COUNT_W'(1);
                fin_status                 = STATUS_OK;
              end
            end
            ACT_UNREGISTER: begin
              if (len_q == '0) begin
                fin = 1'b1;
              end else if (!present_q[item_i.chip_id]) begin
                fin        = 1'b1;
                fin_status = STATUS_NOT_REG;
              end else begin
                state_d = ST_UNREG;
              end
            end
            ACT_BIND: begin
              if ((32'(item_i.cpu) < CPU_COUNT) && (item_i.cpu < CPU_W'(MASK_W)) &&
                  (len_q != '0)) begin
                state_d = ST_BIND;
              end else begin
                fin = 1'b1;
              end
            end
            ACT_UNBIND: begin
              bound_d[item_i.chip_id] = 1'b0;
              fin                     = 1'b1;
              fin_status              = STATUS_OK;
            end
            ACT_GET: begin
              if (item_i.list_position < len_q) begin
                state_d = ST_GET;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_UNREG: begin
        if (p1_vld_q) begin
          // shift later entries down over the removed one
          ord_waddr_o = IdxW'(p1_pos_q - COUNT_W'(1));
          ord_wdata_o = ord_rdata_i;
          ord_we_o    = found_q;
          if (ord_rdata_i == item_q.chip_id) begin
            found_d = 1'b1;
          end
          if (p1_pos_q == last_pos) begin
            len_d                     = last_pos;
            present_d[item_q.chip_id] = 1'b0;
            fin                       = 1'b1;
            fin_status                = STATUS_OK;
          end
        end
      end
      ST_BIND: begin
        if (p1_vld_q) begin
          p2_vld_d  = 1'b1;
          p2_chip_d = ord_rdata_i;
          p2_last_d = (p1_pos_q == last_pos);
        end
        if (p2_vld_q) begin
          if ((dev_rdata_i.rating > best_q) && !bound_q[p2_chip_q] &&
              dev_rdata_i.cpus[item_q.cpu[MASK_IDX_W-1:0]]) begin
            best_d   = dev_rdata_i.rating;
            chosen_d = p2_chip_q;
            got_d    = 1'b1;
          end
          if (p2_last_q) begin
            fin = 1'b1;
            if (got_d) begin
              bound_d[chosen_d] = 1'b1;
              fin_status        = STATUS_OK;
              fin_chip          = chosen_d;
            end
          end
        end
      end
      ST_GET: begin
        fin        = 1'b1;
        fin_status = STATUS_OK;
        fin_chip   = ord_rdata_i;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      len_q          <= '0;
      present_q      <= '0;
      bound_q        <= '0;
      rd_cnt_q       <= '0;
      p1_vld_q       <= 1'b0;
      p2_vld_q       <= 1'b0;
      p2_last_q      <= 1'b0;
      found_q        <= 1'b0;
      got_q          <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      len_q          <= len_d;
      present_q      <= present_d;
      bound_q        <= bound_d;
      rd_cnt_q       <= rd_cnt_d;
      p1_vld_q       <= p1_vld_d;
      p2_vld_q       <= p2_vld_d;
      p2_last_q      <= p2_last_d;
      found_q        <= found_d;
      got_q          <= got_d;
      result_valid_q <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    p1_pos_q  <= p1_pos_d;
    p2_chip_q <= p2_chip_d;
    best_q    <= best_d;
    chosen_q  <= chosen_d;
    if (fin) begin
      result_q.status       <= fin_status;
      result_q.chosen_chip  <= fin_chip;
      result_q.device_count <= len_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

// ===== rtl/core/rated_timer_binding_table.sv =====
// ----------------------------------------------------------------------------
// rated_timer_binding_table
// Ordered registry of timer devices with rating-based CPU binding.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------
//   command  | start high, busy low  | item_i   (item_t)
//   result   | result_valid_o pulse  | result_o (result_t)
//
// Register, unbind and rejected transactions: result in the cycle after accept.
// Get: the read issued at accept is used in the GET state, result registered.
// Unregister and bind scan the order list serially through its RAM read port,
// bind with a second RAM read for the device attributes behind it. Reset
// empties the list at once; no clearing pass. busy is high while a transaction
// is in work; results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rated_timer_binding_table #(
  parameter int MAX_DEVICES = rbt_pkg::MAX_DEVICES_DEF,
  parameter int CPU_COUNT   = rbt_pkg::CPU_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  rbt_pkg::item_t   item_i,
  output logic             result_valid_o,
  output rbt_pkg::result_t result_o
);
  import rbt_pkg::*;

  localparam int IdxW = $clog2(MAX_DEVICES);

  logic              ord_we;
  logic [IdxW-1:0]   ord_waddr;
  logic [CHIP_W-1:0] ord_wdata;
  logic [IdxW-1:0]   ord_raddr;
  logic [CHIP_W-1:0] ord_rdata;
  dev_req_t          dev_req;
  dev_attr_t         dev_rdata;

  rbt_order_mem #(
    .MAX_DEVICES(MAX_DEVICES)
  ) u_order_mem (
    .clk_i  (clk_i),
    .we_i   (ord_we),
    .waddr_i(ord_waddr),
    .wdata_i(ord_wdata),
    .raddr_i(ord_raddr),
    .rdata_o(ord_rdata)
  );

  rbt_dev_mem u_dev_mem (
    .clk_i  (clk_i),
    .req_i  (dev_req),
    .rdata_o(dev_rdata)
  );

  rbt_ctrl #(
    .MAX_DEVICES(MAX_DEVICES),
    .CPU_COUNT  (CPU_COUNT)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .ord_we_o      (ord_we),
    .ord_waddr_o   (ord_waddr),
    .ord_wdata_o   (ord_wdata),
    .ord_raddr_o   (ord_raddr),
    .ord_rdata_i   (ord_rdata),
    .dev_req_o     (dev_req),
    .dev_rdata_i   (dev_rdata)
  );

  `RBT_ASSERT(a_no_result_while_busy, !(result_valid_o && busy), "result while busy")
  `RBT_ASSERT_NXT(a_accept_progress, start && !busy, result_valid_o || busy, "transaction lost")
  `RBT_ASSERT_IMP(a_not_reg_no_chip, result_valid_o && (result_o.status == STATUS_NOT_REG), result_o.chosen_chip == '0, "chip on not-registered")

endmodule
